[sv/pft_pkg.sv]
// Shared types and constants for the polygon fan triangulator.
// Holds the sequencer state type, component indexes, register indexes and vertex count values.
// No dependencies.
package pft_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_CROSS,
		ST_DOT,
		ST_FLUSH,
		ST_EMIT
	} pft_state_t;

	typedef logic [1:0] comp_idx_t;

	localparam comp_idx_t COMP_X = 2'd0;
	localparam comp_idx_t COMP_Y = 2'd1;
	localparam comp_idx_t COMP_Z = 2'd2;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_NORMAL_X = 2'd0;
	localparam reg_idx_t REG_NORMAL_Y = 2'd1;
	localparam reg_idx_t REG_NORMAL_Z = 2'd2;

	typedef logic [1:0] pt_count_t;

	localparam pt_count_t CNT_NONE  = 2'd0;
	localparam pt_count_t CNT_APEX  = 2'd1;
	localparam pt_count_t CNT_READY = 2'd2;

endpackage

[sv/polygon_fan_triangulator.sv]
// Polygon fan triangulator: one fan triangle per vertex from the third on,
// wound to face a configured plane normal. Depends on pft_pkg.
// The first and second vertex of a loop are only stored; a later vertex runs the
// sequencer through difference, cross, dot, flush and emit states, and the next
// vertex is taken once it is back in idle. The one shared multiplier makes 6 passes
// for (e2 x n) and D digit passes for each of the three terms of e1 . (e2 x n),
// with D = ceil((COORD_WIDTH + NORMAL_WIDTH + 2) / NORMAL_WIDTH) (D = 4 at defaults).
// Asynchronous reset clears the vertex count, sequencer and output valid, and sets
// the normal to +z.
module polygon_fan_triangulator #(
	parameter int COORD_WIDTH  = 32,
	parameter int NORMAL_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  pft_pkg::reg_idx_t              cfg_index,
	input  logic signed [NORMAL_WIDTH-1:0] cfg_data,
	input  logic                           pt_valid,
	output logic                           pt_ready,
	input  logic signed [COORD_WIDTH-1:0]  point_x,
	input  logic signed [COORD_WIDTH-1:0]  point_y,
	input  logic signed [COORD_WIDTH-1:0]  point_z,
	input  logic                           loop_end,
	output logic                           tri_valid,
	input  logic                           tri_ready,
	output logic signed [COORD_WIDTH-1:0]  apex_x,
	output logic signed [COORD_WIDTH-1:0]  apex_y,
	output logic signed [COORD_WIDTH-1:0]  apex_z,
	output logic signed [COORD_WIDTH-1:0]  second_x,
	output logic signed [COORD_WIDTH-1:0]  second_y,
	output logic signed [COORD_WIDTH-1:0]  second_z,
	output logic signed [COORD_WIDTH-1:0]  third_x,
	output logic signed [COORD_WIDTH-1:0]  third_y,
	output logic signed [COORD_WIDTH-1:0]  third_z,
	output logic                           final_triangle
);
	import pft_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int NW  = NORMAL_WIDTH;
	localparam int DW  = CW + 1;              // edge vector component
	localparam int WW  = DW + NW + 1;         // component of e2 x n
	localparam int DIG = (WW + NW - 1) / NW;  // digits of w per dot term
	localparam int SW  = (DIG > 2) ? $clog2(DIG) : 1;
	localparam int PW  = DW + NW + 1;         // one partial product
	localparam int AW  = DW + WW + 2;         // full dot product
	localparam int XW  = DIG * NW;            // w sign-extended to whole digits

	localparam logic signed [NW-1:0] NRM_ONE = {2'b01, {(NW-2){1'b0}}};

	// state
	pft_state_t state_q, state_nxt;
	pt_count_t  cnt_q;

	logic signed [NW-1:0] nrm_q [3];
	logic signed [NW-1:0] nrm_eff [3];

	logic signed [CW-1:0] anc_q [3];
	logic signed [CW-1:0] prv_q [3];
	logic signed [CW-1:0] cur_q [3];
	logic                 last_q;
	logic signed [DW-1:0] e1_q [3];
	logic signed [DW-1:0] e2_q [3];
	logic signed [WW-1:0] w_q [3];
	logic signed [AW-1:0] acc_q;
	logic                 swap_q;

	comp_idx_t     comp_q;
	logic [SW-1:0] sub_q;

	// product stage
	logic                 pv_s1;
	logic signed [PW-1:0] prod_s1;
	logic                 neg_s1;
	logic [SW-1:0]        dig_s1;
	logic                 wr_s1;
	comp_idx_t            wi_s1;
	logic                 fin_s1;

	// output register
	logic                 tri_valid_q;
	logic                 final_q;
	logic signed [CW-1:0] apex_q [3];
	logic signed [CW-1:0] sec_q [3];
	logic signed [CW-1:0] thd_q [3];

	logic pt_acc;
	logic issue;
	logic emit_go;
	logic last_sub;
	logic is_dot;

	comp_idx_t comp_p1, comp_p2, a_idx, b_idx;
	logic signed [DW-1:0] mul_a;
	logic signed [NW:0]   mul_b;
	logic signed [PW-1:0] prod;
	logic signed [XW-1:0] w_ext;
	logic [NW-1:0]        w_dig;
	logic signed [AW-1:0] p_ext, p_sh, acc_nxt;
	logic                 nrm_zero;

	always_comb begin
		nrm_zero   = (nrm_q[0] == '0) && (nrm_q[1] == '0) && (nrm_q[2] == '0);
		nrm_eff[0] = nrm_zero ? '0 : nrm_q[0];
		nrm_eff[1] = nrm_zero ? '0 : nrm_q[1];
		nrm_eff[2] = nrm_zero ? NRM_ONE : nrm_q[2];
	end

	// sequencer: next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (pt_valid && cnt_q == CNT_READY) state_nxt = ST_DIFF;
			ST_DIFF:  state_nxt = ST_CROSS;
			ST_CROSS: if (last_sub && comp_q == COMP_Z) state_nxt = ST_DOT;
			ST_DOT:   if (last_sub && comp_q == COMP_Z) state_nxt = ST_FLUSH;
			ST_FLUSH: state_nxt = ST_EMIT;
			ST_EMIT:  if (!tri_valid_q || tri_ready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		pt_ready = 1'b0;
		issue    = 1'b0;
		emit_go  = 1'b0;
		is_dot   = 1'b0;
		unique case (state_q)
			ST_IDLE:  pt_ready = 1'b1;
			ST_CROSS: issue = 1'b1;
			ST_DOT: begin
				issue  = 1'b1;
				is_dot = 1'b1;
			end
			ST_EMIT:  emit_go = !tri_valid_q || tri_ready;
			default: ;
		endcase
	end

	assign pt_acc   = pt_valid && pt_ready;
	assign last_sub = is_dot ? (sub_q == SW'(DIG - 1)) : (sub_q == SW'(1));

	always_comb begin
		comp_p1 = (comp_q == COMP_Z) ? COMP_X : comp_idx_t'(comp_q + 2'd1);
		comp_p2 = (comp_q == COMP_X) ? COMP_Z : comp_idx_t'(comp_q - 2'd1);
	end

	// operand selection for the shared multiplier
	always_comb begin
		w_ext = XW'(w_q[comp_q]);
		w_dig = '0;
		for (int j = 0; j < DIG; j++) begin
			if (sub_q == SW'(j)) w_dig = w_ext[j*NW +: NW];
		end
		// w = e2 x n: term one is e2[c+1]*n[c+2], term two subtracts e2[c+2]*n[c+1]
		a_idx = sub_q[0] ? comp_p2 : comp_p1;
		b_idx = sub_q[0] ? comp_p1 : comp_p2;
		if (is_dot) begin
			mul_a = e1_q[comp_q];
			// low digits are unsigned, the top digit carries the sign
			mul_b = (sub_q == SW'(DIG - 1)) ? {w_dig[NW-1], w_dig} : {1'b0, w_dig};
		end else begin
			mul_a = e2_q[a_idx];
			mul_b = {nrm_eff[b_idx][NW-1], nrm_eff[b_idx]};
		end
		prod = PW'(mul_a) * PW'(mul_b);
	end

	// accumulate
	always_comb begin
		p_ext = {{(AW-PW){prod_s1[PW-1]}}, prod_s1};
		p_sh  = p_ext;
		for (int j = 0; j < DIG; j++) begin
			if (dig_s1 == SW'(j)) p_sh = p_ext <<< (j * NW);
		end
		acc_nxt = neg_s1 ? (acc_q - p_sh) : (acc_q + p_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= CNT_NONE;
			comp_q      <= COMP_X;
			sub_q       <= '0;
			pv_s1       <= 1'b0;
			tri_valid_q <= 1'b0;
			nrm_q[0]    <= '0;
			nrm_q[1]    <= '0;
			nrm_q[2]    <= NRM_ONE;
		end else begin
			state_q <= state_nxt;
			pv_s1   <= issue;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NORMAL_X: nrm_q[0] <= cfg_data;
					REG_NORMAL_Y: nrm_q[1] <= cfg_data;
					REG_NORMAL_Z: nrm_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (pt_acc) begin
				unique case (cnt_q)
					CNT_NONE:  cnt_q <= loop_end ? CNT_NONE : CNT_APEX;
					CNT_APEX:  cnt_q <= loop_end ? CNT_NONE : CNT_READY;
					CNT_READY: cnt_q <= loop_end ? CNT_NONE : CNT_READY;
					default:   cnt_q <= CNT_NONE;
				endcase
			end
			if (state_q == ST_DIFF) begin
				comp_q <= COMP_X;
				sub_q  <= '0;
			end else if (issue) begin
				if (last_sub) begin
					sub_q  <= '0;
					comp_q <= comp_p1;
				end else begin
					sub_q <= sub_q + SW'(1);
				end
			end
			if (emit_go) begin
				tri_valid_q <= 1'b1;
			end else if (tri_ready) begin
				tri_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (pt_acc) begin
			if (cnt_q == CNT_NONE) begin
				anc_q[0] <= point_x;
				anc_q[1] <= point_y;
				anc_q[2] <= point_z;
			end
			if (cnt_q == CNT_APEX) begin
				prv_q[0] <= point_x;
				prv_q[1] <= point_y;
				prv_q[2] <= point_z;
			end
			cur_q[0] <= point_x;
			cur_q[1] <= point_y;
			cur_q[2] <= point_z;
			last_q   <= loop_end;
		end

		if (state_q == ST_DIFF) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= {prv_q[k][CW-1], prv_q[k]} - {anc_q[k][CW-1], anc_q[k]};
				e2_q[k] <= {cur_q[k][CW-1], cur_q[k]} - {anc_q[k][CW-1], anc_q[k]};
			end
		end

		prod_s1 <= prod;
		neg_s1  <= !is_dot && sub_q[0];
		dig_s1  <= is_dot ? sub_q : '0;
		wr_s1   <= !is_dot && last_sub;
		wi_s1   <= comp_q;
		fin_s1  <= is_dot && last_sub && comp_q == COMP_Z;

		if (state_q == ST_DIFF) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			if (wr_s1) begin
				w_q[wi_s1] <= acc_nxt[WW-1:0];
				acc_q      <= '0;
			end else if (fin_s1) begin
				// negative dot product: triangle faces away, swap the last two
				swap_q <= acc_nxt[AW-1];
			end else begin
				acc_q <= acc_nxt;
			end
		end

		if (emit_go) begin
			for (int k = 0; k < 3; k++) begin
				apex_q[k] <= anc_q[k];
				sec_q[k]  <= swap_q ? cur_q[k] : prv_q[k];
				thd_q[k]  <= swap_q ? prv_q[k] : cur_q[k];
				prv_q[k]  <= cur_q[k];
			end
			final_q <= last_q;
		end
	end

	assign tri_valid      = tri_valid_q;
	assign apex_x         = apex_q[0];
	assign apex_y         = apex_q[1];
	assign apex_z         = apex_q[2];
	assign second_x       = sec_q[0];
	assign second_y       = sec_q[1];
	assign second_z       = sec_q[2];
	assign third_x        = thd_q[0];
	assign third_y        = thd_q[1];
	assign third_z        = thd_q[2];
	assign final_triangle = final_q;

endmodule
